// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, constants and stage payload types of the ray/triangle pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rti_pkg;

   localparam int CW   = 32;          // coordinate
   localparam int EW   = CW + 1;      // edge / tvec
   localparam int PW   = 2 * EW;      // pvec component
   localparam int QW   = 2 * EW + 1;  // qvec component
   localparam int XW   = QW + 1;      // wide operand of the dot products
   localparam int LOW  = 34;          // low slice of the wide operand
   localparam int HIW  = XW - LOW;    // high slice (signed)
   localparam int SW   = 104;         // det and numerators
   localparam int DVW  = SW + 32;     // divider remainder
   localparam int QTW  = 31;          // quotient / distance
   localparam int FRAC = 16;

   localparam logic [1:0] REG_DIR_X = 2'd0;
   localparam logic [1:0] REG_DIR_Y = 2'd1;
   localparam logic [1:0] REG_DIR_Z = 2'd2;

   localparam logic [CW-1:0]  DIR_Z_RESET = 32'h0001_0000;
   // ceil(0.0001 * 2^48)
   localparam logic [SW-1:0]  DET_EPS     = 104'd28147497672;
   localparam logic [QTW-1:0] DIST_MAX    = {QTW{1'b1}};

   typedef logic [2:0][CW-1:0] cvec_type;

   typedef struct packed {
      cvec_type org;
      cvec_type a;
      cvec_type b;
      cvec_type c;
   } tri_type;

   typedef struct packed {
      logic [2:0][EW-1:0] e0;
      logic [2:0][EW-1:0] e1;
      logic [2:0][EW-1:0] tv;
      logic [2:0][PW-1:0] pv;
      logic [2:0][QW-1:0] qv;
   } front_type;

   typedef struct packed {
      logic [SW-1:0] det;
      logic [SW-1:0] nu;
      logic [SW-1:0] nv;
      logic [SW-1:0] nt;
   } dot_type;

   typedef struct packed {
      logic           hit;
      logic           sat;
      logic [DVW-1:0] rem;
      logic [SW-1:0]  den;
      logic [QTW-1:0] quo;
   } div_type;

endpackage

// ===== hw/rtl/rti_front.sv =====
// ----------------------------------------------------------------------------
// rti_front
// Edges, tvec and the pvec/qvec cross products, three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_front (
   input  logic               clock,
   input  logic               reset,
   input  rti_pkg::cvec_type  dir,
   input  logic               in_valid,
   output logic               in_ready,
   input  rti_pkg::tri_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rti_pkg::front_type out_data
);
   import rti_pkg::*;

   localparam int NST = 3;
   localparam int DPW = CW + EW;
   localparam int TPW = 2 * EW;
   localparam int J_IDX [3] = '{1, 2, 0};
   localparam int K_IDX [3] = '{2, 0, 1};

   typedef struct packed {
      logic [2:0][EW-1:0] e0;
      logic [2:0][EW-1:0] e1;
      logic [2:0][EW-1:0] tv;
   } edges_type;

   typedef struct packed {
      logic [2:0][EW-1:0]  e0;
      logic [2:0][EW-1:0]  e1;
      logic [2:0][EW-1:0]  tv;
      logic [2:0][DPW-1:0] pa;
      logic [2:0][DPW-1:0] pb;
      logic [2:0][TPW-1:0] qa;
      logic [2:0][TPW-1:0] qb;
   } prod_type;

   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST:0]   adv;

   edges_type s1_ff, s1_in;
   prod_type  s2_ff, s2_in;
   front_type s3_ff, s3_in;

   always_comb begin
      adv[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[NST-2:0], in_valid};
   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NST-1];
   assign out_data  = s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_in.e0[i] = $signed({in_data.b[i][CW-1], in_data.b[i]})
                     - $signed({in_data.a[i][CW-1], in_data.a[i]});
         s1_in.e1[i] = $signed({in_data.c[i][CW-1], in_data.c[i]})
                     - $signed({in_data.a[i][CW-1], in_data.a[i]});
         s1_in.tv[i] = $signed({in_data.org[i][CW-1], in_data.org[i]})
                     - $signed({in_data.a[i][CW-1], in_data.a[i]});
      end
   end

   always_comb begin
      logic signed [DPW-1:0] ta, tb;
      logic signed [TPW-1:0] ua, ub;
      s2_in.e0 = s1_ff.e0;
      s2_in.e1 = s1_ff.e1;
      s2_in.tv = s1_ff.tv;
      for (int i = 0; i < 3; i++) begin
         ta = $signed(dir[J_IDX[i]]) * $signed(s1_ff.e1[K_IDX[i]]);
         tb = $signed(dir[K_IDX[i]]) * $signed(s1_ff.e1[J_IDX[i]]);
         ua = $signed(s1_ff.tv[J_IDX[i]]) * $signed(s1_ff.e0[K_IDX[i]]);
         ub = $signed(s1_ff.tv[K_IDX[i]]) * $signed(s1_ff.e0[J_IDX[i]]);
         s2_in.pa[i] = ta;
         s2_in.pb[i] = tb;
         s2_in.qa[i] = ua;
         s2_in.qb[i] = ub;
      end
   end

   always_comb begin
      logic signed [PW-1:0] pd;
      logic signed [QW-1:0] qd;
      s3_in.e0 = s2_ff.e0;
      s3_in.e1 = s2_ff.e1;
      s3_in.tv = s2_ff.tv;
      for (int i = 0; i < 3; i++) begin
         pd = $signed(s2_ff.pa[i]) - $signed(s2_ff.pb[i]);
         qd = $signed(s2_ff.qa[i]) - $signed(s2_ff.qb[i]);
         s3_in.pv[i] = pd;
         s3_in.qv[i] = qd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
   end

endmodule

// ===== hw/rtl/rti_dot.sv =====
// ----------------------------------------------------------------------------
// rti_dot
// det and the u, v, t numerators: split partial products, merge, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_dot (
   input  logic               clock,
   input  logic               reset,
   input  rti_pkg::cvec_type  dir,
   input  logic               in_valid,
   output logic               in_ready,
   input  rti_pkg::front_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rti_pkg::dot_type   out_data
);
   import rti_pkg::*;

   localparam int NST = 3;
   localparam int NDOT = 4;
   localparam int PLW = EW + LOW + 1;
   localparam int PHW = EW + HIW;

   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST:0]   adv;

   logic [EW-1:0]  op_a [NDOT][3];
   logic [XW-1:0]  op_w [NDOT][3];

   logic signed [PLW-1:0] pl_ff [NDOT][3];
   logic signed [PLW-1:0] pl_in [NDOT][3];
   logic signed [PHW-1:0] ph_ff [NDOT][3];
   logic signed [PHW-1:0] ph_in [NDOT][3];
   logic signed [SW-1:0]  pr_ff [NDOT][3];
   logic signed [SW-1:0]  pr_in [NDOT][3];
   logic signed [SW-1:0]  sum_ff [NDOT];
   logic signed [SW-1:0]  sum_in [NDOT];

   always_comb begin
      adv[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[NST-2:0], in_valid};
   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // rows: det = e0.pv, nu = tv.pv, nv = dir.qv, nt = e1.qv
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         op_a[0][i] = in_data.e0[i];
         op_a[1][i] = in_data.tv[i];
         op_a[2][i] = {dir[i][CW-1], dir[i]};
         op_a[3][i] = in_data.e1[i];
         op_w[0][i] = {{(XW-PW){in_data.pv[i][PW-1]}}, in_data.pv[i]};
         op_w[1][i] = {{(XW-PW){in_data.pv[i][PW-1]}}, in_data.pv[i]};
         op_w[2][i] = {{(XW-QW){in_data.qv[i][QW-1]}}, in_data.qv[i]};
         op_w[3][i] = {{(XW-QW){in_data.qv[i][QW-1]}}, in_data.qv[i]};
      end
   end

   always_comb begin
      for (int m = 0; m < NDOT; m++) begin
         for (int i = 0; i < 3; i++) begin
            pl_in[m][i] = $signed(op_a[m][i]) * $signed({1'b0, op_w[m][i][LOW-1:0]});
            ph_in[m][i] = $signed(op_a[m][i]) * $signed(op_w[m][i][XW-1:LOW]);
            pr_in[m][i] = (ph_ff[m][i] <<< LOW) + pl_ff[m][i];
         end
         sum_in[m] = pr_ff[m][0] + pr_ff[m][1] + pr_ff[m][2];
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < NDOT; m++) begin
         for (int i = 0; i < 3; i++) begin
            if (adv[0]) begin
               pl_ff[m][i] <= pl_in[m][i];
               ph_ff[m][i] <= ph_in[m][i];
            end
            if (adv[1]) begin
               pr_ff[m][i] <= pr_in[m][i];
            end
         end
         if (adv[2]) begin
            sum_ff[m] <= sum_in[m];
         end
      end
   end

   assign out_data.det = sum_ff[0];
   assign out_data.nu  = sum_ff[1];
   assign out_data.nv  = sum_ff[2];
   assign out_data.nt  = sum_ff[3];

endmodule

// ===== hw/rtl/rti_test.sv =====
// ----------------------------------------------------------------------------
// rti_test
// Folds the sign of det, runs the range tests and the saturation check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_test (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rti_pkg::dot_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rti_pkg::div_type out_data
);
   import rti_pkg::*;

   localparam int NST = 2;

   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST:0]   adv;

   dot_type fold_ff, fold_in;
   div_type chk_ff, chk_in;

   always_comb begin
      adv[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[NST-2:0], in_valid};
   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NST-1];
   assign out_data  = chk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_comb begin
      if (in_data.det[SW-1]) begin
         fold_in.det = -in_data.det;
         fold_in.nu  = -in_data.nu;
         fold_in.nv  = -in_data.nv;
         fold_in.nt  = -in_data.nt;
      end else begin
         fold_in = in_data;
      end
   end

   always_comb begin
      logic [SW-1:0] uv;
      logic          miss;
      uv   = fold_ff.nu + fold_ff.nv;
      miss = (fold_ff.det < DET_EPS)
          || fold_ff.nu[SW-1] || ($signed(fold_ff.nu) > $signed(fold_ff.det))
          || fold_ff.nv[SW-1] || ($signed(uv) > $signed(fold_ff.det))
          || fold_ff.nt[SW-1];
      chk_in.hit = !miss;
      // quotient reaches 2^31 exactly when nt >= det * 2^15
      chk_in.sat = DVW'(fold_ff.nt) >= (DVW'(fold_ff.det) << (QTW - FRAC));
      chk_in.rem = DVW'(fold_ff.nt) << FRAC;
      chk_in.den = fold_ff.det;
      chk_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         fold_ff <= fold_in;
      end
      if (adv[1]) begin
         chk_ff <= chk_in;
      end
   end

endmodule

// ===== hw/rtl/rti_div.sv =====
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rti_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rti_pkg::div_type out_data
);
   import rti_pkg::*;

   localparam int NST = QTW;

   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST:0]   adv;

   div_type st_ff [NST];
   div_type st_in [NST];
   div_type src   [NST];

   always_comb begin
      adv[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[NST-2:0], in_valid};
   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NST-1];
   assign out_data  = st_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_comb begin
      logic [DVW-1:0] dsh;
      logic           ge;
      src[0] = in_data;
      for (int s = 1; s < NST; s++) begin
         src[s] = st_ff[s-1];
      end
      for (int s = 0; s < NST; s++) begin
         dsh = DVW'(src[s].den) << (QTW - 1 - s);
         ge  = src[s].rem >= dsh;
         st_in[s]     = src[s];
         st_in[s].rem = ge ? src[s].rem - dsh : src[s].rem;
         st_in[s].quo = {src[s].quo[QTW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NST; s++) begin
         if (adv[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

endmodule

// ===== hw/rtl/ray_triangle_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Two-sided ray/triangle hit test in exact Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | carries
//   --------+--------------------------------+-------------------------------
//   req     | req_valid / req_stall          | ray origin and vertices a,b,c
//   rsp     | rsp_valid / rsp_stall          | hit flag and distance
//   csr     | csr_we, csr_index, csr_wdata   | ray direction x, y, z
//
// One item per cycle sustained while rsp_stall is low. Stages: 3 cross-product stages,
// 3 dot-product stages, 2 test stages, 31 divider stages, one per bit.
// Every stage has its own valid bit; a stage moves when the next one is
// empty or moving, so bubbles close up under rsp_stall.
// Synchronous reset clears the valid bits and loads direction +Z.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ray_triangle_intersect_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_org_x,
   input  logic signed [31:0] req_org_y,
   input  logic signed [31:0] req_org_z,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_c_x,
   input  logic signed [31:0] req_c_y,
   input  logic signed [31:0] req_c_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic        [30:0] rsp_distance,
   input  logic               csr_we,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_wdata
);
   import rti_pkg::*;

   cvec_type  dir_ff;
   tri_type   tri_in;
   front_type front_data;
   dot_type   dot_data;
   div_type   test_data;
   div_type   div_data;

   logic front_ready, front_valid;
   logic dot_ready, dot_valid;
   logic test_ready, test_valid;
   logic div_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= DIR_Z_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DIR_X: dir_ff[0] <= csr_wdata;
            REG_DIR_Y: dir_ff[1] <= csr_wdata;
            REG_DIR_Z: dir_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign tri_in.org = {req_org_z, req_org_y, req_org_x};
   assign tri_in.a   = {req_a_z, req_a_y, req_a_x};
   assign tri_in.b   = {req_b_z, req_b_y, req_b_x};
   assign tri_in.c   = {req_c_z, req_c_y, req_c_x};

   rti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .dir       (dir_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (tri_in),
      .out_valid (front_valid),
      .out_ready (dot_ready),
      .out_data  (front_data)
   );

   rti_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .dir       (dir_ff),
      .in_valid  (front_valid),
      .in_ready  (dot_ready),
      .in_data   (front_data),
      .out_valid (dot_valid),
      .out_ready (test_ready),
      .out_data  (dot_data)
   );

   rti_test u_test (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .in_ready  (test_ready),
      .in_data   (dot_data),
      .out_valid (test_valid),
      .out_ready (div_ready),
      .out_data  (test_data)
   );

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (test_valid),
      .in_ready  (div_ready),
      .in_data   (test_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (div_data)
   );

   assign req_stall    = !front_ready;
   assign rsp_hit      = div_data.hit;
   assign rsp_distance = !div_data.hit ? '0 : (div_data.sat ? DIST_MAX : div_data.quo);

   // input backs up only when every stage is full and the output is held
   `ASSERT_IMPLIES(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ASSERT_NEXT(a_csr_dir_x, clock, reset, csr_we && csr_index == REG_DIR_X, dir_ff[0] == $past(csr_wdata))
   `ASSERT_IMPLIES(a_reset_dir, clock, reset, $past(reset), dir_ff[2] == DIR_Z_RESET && dir_ff[0] == '0)

endmodule
